>>> hw/rtl/block_mean_downscaler_top_macros.svh
// Assertion macros shared by the block-mean downscaler RTL.
`ifndef BLOCK_MEAN_DOWNSCALER_TOP_MACROS_SVH
`define BLOCK_MEAN_DOWNSCALER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BMD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bmd: invariant violated");
`define BMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmd: sequence violated");
`else
`define BMD_ASSERT_ALWAYS(label, cond)
`define BMD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/bmd_pkg.sv
package bmd_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_BLOCK = 16;
  localparam int PIX_W     = 16;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int OC_W    = COL_W + 1;
  localparam int TIL_W   = $clog2(MAX_BLOCK);
  localparam int SIDE_W  = 5;
  localparam int WIDTH_W = 13;
  localparam int HSUM_W  = PIX_W + TIL_W;
  localparam int SUM_W   = PIX_W + 2 * TIL_W;
  localparam int SQ_W    = 2 * TIL_W + 1;
  localparam int DEN_W   = SQ_W + 1;
  localparam int NUM_W   = SUM_W + 2;
  localparam int REM_W   = DEN_W - 1;
  localparam int STEP_W  = $clog2(NUM_W);
  localparam int PROD_W  = OC_W + SIDE_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_BLOCK_SIDE  = 1'b0;
  localparam logic REG_IMAGE_WIDTH = 1'b1;

  localparam logic [SIDE_W-1:0]  SIDE_RESET  = SIDE_W'(2);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [TIL_W-1:0]   side_m1;
    logic [WIDTH_W-1:0] width;
    logic [SQ_W-1:0]    sq;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

endpackage

>>> hw/rtl/bmd_regs.sv
module bmd_regs import bmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic [SIDE_W-1:0]  raw_side;
  logic [WIDTH_W-1:0] raw_width;
  logic [SIDE_W-1:0]  wr_side;
  logic [WIDTH_W-1:0] wr_width;
  logic [SIDE_W-1:0]  eff_side;
  logic [WIDTH_W-1:0] eff_width;
  logic [2*SIDE_W-1:0] eff_sq;
  logic               wr_en;

  assign wr_en    = psel && penable && pwrite;
  assign wr_side  = pwdata[SIDE_W-1:0];
  assign wr_width = pwdata[WIDTH_W-1:0];

  always_comb begin
    if (wr_side == '0) begin
      eff_side = SIDE_W'(1);
    end else if (wr_side > SIDE_W'(MAX_BLOCK)) begin
      eff_side = SIDE_W'(MAX_BLOCK);
    end else begin
      eff_side = wr_side;
    end
    if (wr_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (wr_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = wr_width;
    end
    eff_sq = (2*SIDE_W)'(eff_side) * (2*SIDE_W)'(eff_side);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_side    <= SIDE_RESET;
      raw_width   <= WIDTH_RESET;
      cfg.side    <= SIDE_RESET;
      cfg.side_m1 <= TIL_W'(SIDE_RESET - SIDE_W'(1));
      cfg.width   <= WIDTH_RESET;
      cfg.sq      <= SQ_W'(SIDE_RESET * SIDE_RESET);
    end else if (wr_en) begin
      case (paddr[2])
        REG_BLOCK_SIDE: begin
          raw_side    <= wr_side;
          cfg.side    <= eff_side;
          cfg.side_m1 <= TIL_W'(eff_side - SIDE_W'(1));
          cfg.sq      <= eff_sq[SQ_W-1:0];
        end
        REG_IMAGE_WIDTH: begin
          raw_width <= wr_width;
          cfg.width <= eff_width;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLOCK_SIDE:  prdata = APB_DW'(raw_side);
      REG_IMAGE_WIDTH: prdata = APB_DW'(raw_width);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/bmd_line_buf.sv
module bmd_line_buf import bmd_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [SUM_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [SUM_W-1:0] rd_data
);

  logic [SUM_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/bmd_div.sv
module bmd_div import bmd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic             take,
  output logic             res_valid,
  output logic [PIX_W-1:0] quot
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dstate_t;

  dstate_t           state;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  sh;
  logic [DEN_W-1:0]  diff;
  logic              ge;

  assign sh        = {rem, num[NUM_W-1]};
  assign ge        = sh >= den;
  assign diff      = sh - den;
  assign res_valid = (state == D_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (req.start) begin
            num   <= req.numer;
            den   <= req.denom;
            rem   <= '0;
            cnt   <= STEP_W'(NUM_W - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          num  <= {num[NUM_W-2:0], 1'b0};
          rem  <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
          quot <= {quot[PIX_W-2:0], ge};
          if (cnt == '0) begin
            state <= D_DONE;
          end else begin
            cnt <= cnt - STEP_W'(1);
          end
        end
        D_DONE: begin
          if (take) begin
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/block_mean_downscaler_top.sv
// Channel   Direction  Handshake                  Beat payload
// pixel     in         in_valid / in_ready        pixel_in, frame_start
// mean      out        out_valid / out_ready      mean_pixel, row_last
// config    in         APB psel/penable/pready    block_side at 0x0, image_width at 0x4
//
// A pixel inside a tile row is accepted in the idle state. The pixel that closes a tile's
// row also passes through merge: the column sum is read from the line buffer as it is
// accepted, then written back in merge, or sent to the divider on the tile's last row;
// the divider retires one quotient bit per cycle over the 26-bit rounded numerator.
// Reset is synchronous and clears the counters and control; the line buffer is not
// cleared. A held result only stalls input once the next tile is ready to leave.
`include "block_mean_downscaler_top_macros.svh"

module block_mean_downscaler_top import bmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic [PIX_W-1:0]  pixel_in,
  input  logic              frame_start,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [PIX_W-1:0]  mean_pixel,
  output logic              row_last,
  output logic              out_valid,
  input  logic              out_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_DIV
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic [COL_W-1:0]  ic;
  logic [TIL_W-1:0]  cit;
  logic [TIL_W-1:0]  rit;
  logic [OC_W-1:0]   oc;
  logic [HSUM_W-1:0] hs;

  logic [COL_W-1:0]  ic0;
  logic [TIL_W-1:0]  cit0;
  logic [TIL_W-1:0]  rit0;
  logic [OC_W-1:0]   oc0;
  logic [HSUM_W-1:0] hs0;
  logic [HSUM_W-1:0] hs1;
  logic [OC_W-1:0]   oc_inc;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] tail;
  logic [WIDTH_W-1:0] ic_inc;
  logic              active;
  logic              last_tile;
  logic              flush;
  logic              last_row;
  logic              row_end;
  logic              acc;

  logic [HSUM_W-1:0] it_hs;
  logic              it_rdsum;
  logic              it_emit;
  logic              it_last;
  logic [COL_W-1:0]  it_addr;

  logic              lb_wr_en;
  logic              lb_rd_en;
  logic [SUM_W-1:0]  lb_rd_data;
  logic [SUM_W-1:0]  total;

  div_req_t          div_req;
  logic              div_take;
  logic              div_res_valid;
  logic [PIX_W-1:0]  div_quot;
  logic              out_free;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ic0       = frame_start ? '0 : ic;
    cit0      = frame_start ? '0 : cit;
    rit0      = frame_start ? '0 : rit;
    oc0       = frame_start ? '0 : oc;
    hs0       = frame_start ? '0 : hs;
    hs1       = hs0 + HSUM_W'(pixel_in);
    oc_inc    = oc0 + OC_W'(1);
    prod      = PROD_W'(oc_inc) * PROD_W'(cfg.side);
    tail      = prod + PROD_W'(cfg.side);
    active    = prod <= PROD_W'(cfg.width);
    last_tile = tail > PROD_W'(cfg.width);
    flush     = active && (cit0 >= cfg.side_m1);
    last_row  = rit0 >= cfg.side_m1;
    ic_inc    = WIDTH_W'(ic0) + WIDTH_W'(1);
    row_end   = ic_inc >= cfg.width;
  end

  assign lb_rd_en = acc && flush && (rit0 != '0);
  assign total    = SUM_W'(it_hs) + (it_rdsum ? lb_rd_data : '0);
  assign lb_wr_en = (state == S_MERGE) && !it_emit;

  assign div_req.start = (state == S_MERGE) && it_emit;
  assign div_req.numer = NUM_W'({total, 1'b0}) + NUM_W'(cfg.sq);
  assign div_req.denom = {cfg.sq, 1'b0};
  assign div_take      = (state == S_DIV) && div_res_valid && out_free;

  bmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  bmd_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (lb_wr_en),
    .wr_addr (it_addr),
    .wr_data (total),
    .rd_en   (lb_rd_en),
    .rd_addr (oc0[COL_W-1:0]),
    .rd_data (lb_rd_data)
  );

  bmd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .take      (div_take),
    .res_valid (div_res_valid),
    .quot      (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ic        <= '0;
      cit       <= '0;
      rit       <= '0;
      oc        <= '0;
      hs        <= '0;
    end else begin
      if (out_valid && out_ready && !div_take) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            it_hs    <= hs1;
            it_rdsum <= rit0 != '0;
            it_emit  <= last_row;
            it_last  <= last_tile;
            it_addr  <= oc0[COL_W-1:0];
            if (flush) begin
              state <= S_MERGE;
            end
            if (row_end) begin
              ic  <= '0;
              cit <= '0;
              oc  <= '0;
              hs  <= '0;
              rit <= last_row ? '0 : rit0 + TIL_W'(1);
            end else begin
              ic  <= ic_inc[COL_W-1:0];
              rit <= rit0;
              if (!active) begin
                cit <= cit0;
                oc  <= oc0;
                hs  <= hs0;
              end else if (flush) begin
                cit <= '0;
                oc  <= oc_inc;
                hs  <= '0;
              end else begin
                cit <= cit0 + TIL_W'(1);
                oc  <= oc0;
                hs  <= hs1;
              end
            end
          end
        end
        S_MERGE: begin
          state <= it_emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_take) begin
            out_valid  <= 1'b1;
            mean_pixel <= div_quot;
            row_last   <= it_last;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BMD_ASSERT_ALWAYS(a_lb_single_port, !(lb_wr_en && lb_rd_en))
  `BMD_ASSERT_NEXT(a_flush_merges, acc && flush, state == S_MERGE)
  `BMD_ASSERT_ALWAYS(a_div_owned, !div_res_valid || state == S_DIV)

endmodule
